>>> design/mls_pkg.sv
// Shared types and constants for the Mercator ln(1+x) series core.
// Depends on nothing; the top level, mls_dpath and mls_ctrl import it.
package mls_pkg;

   localparam int X_W            = 32;      // width of the x argument
   localparam int N_W            = 20;      // width of the term count and term index
   localparam int ACC_W          = 40;      // width of the saturating accumulator
   localparam int FRAC_BITS_DEF  = 30;      // default number of fraction bits
   localparam logic [N_W-1:0] TERM_COUNT_RST = N_W'(200000);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a new argument and clear the sum
      logic start;      // launch the divider and the power multiply for one term
      logic update;     // fold the finished term into the sum, advance the power
      logic out_load;   // copy the sum into the result register
   } mls_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic p_zero;     // running power has reached zero
      logic n_last;     // current term index equals the term count
      logic tc_zero;    // term count is zero
      logic div_done;   // divider quotient is valid this cycle
   } mls_sts_type;

endpackage

>>> design/mercator_log1p_series_core.sv
// Top level of the Mercator series core computing ln(1+x) in fixed point.
// Depends on mls_pkg, mls_ctrl, mls_dpath and mls_div.
//
//   Channel   Direction  Payload                               Handshake
//   req_*     in         tdata[31:0] = x_value (signed)        tvalid / tready
//   rsp_*     out        tdata[39:0] = log_value (signed),     tvalid / tready
//                        tuser[0] = saturated
//   csr_*     in         wdata[19:0] = term_count              we, no wait
//
// One request is worked on at a time. After the load, each term runs the
// one-bit-per-cycle divider that forms power / n with MAG_W quotient bits
// (MAG_W = FRAC_BITS + 1 when FRAC_BITS is below 31, otherwise 32).
// Summation ends early once the running power reaches zero.
// Reset is synchronous and active high; it restores term_count to 200000.
// A finished result waits in the output register while the next request is
// already accepted and summed; only handing over a second result stalls.
module mercator_log1p_series_core #(
   parameter int FRAC_BITS = mls_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Requests: tdata holds x_value.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [mls_pkg::X_W-1:0]   req_tdata,   // [31:0] x_value
   // Results: tdata holds log_value, tuser holds saturated.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [mls_pkg::ACC_W-1:0] rsp_tdata,   // [39:0] log_value
   output logic                      rsp_tuser,   // [0] saturated
   // Term count register write.
   input  logic                      csr_we,
   input  logic [mls_pkg::N_W-1:0]   csr_wdata    // [19:0] term_count
);

   import mls_pkg::*;

   mls_cmd_type cmd;
   mls_sts_type sts;

   // The controller sequences load, per-term divide and update, and result hand-off.
   mls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the term count, running power, accumulator and result.
   mls_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

>>> design/mls_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module mls_div #(
   parameter int DVD_W = 31,
   parameter int DVR_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quot_ff, quot_in;
   logic [DVR_W-1:0] rem_ff, rem_in;
   logic [DVR_W-1:0] dvr_ff, dvr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVR_W:0]   trial;
   logic [DVR_W:0]   diff;

   // The partial remainder picks up the next dividend bit; subtract if it fits.
   assign trial = {rem_ff, quot_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvr_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvr_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvr_ff}) begin
            rem_in  = diff[DVR_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DVR_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvr_ff  <= dvr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> design/mls_dpath.sv
// Datapath of the series core: argument clamp, running power, divider, accumulator.
// Depends on mls_pkg and mls_div.
module mls_dpath #(
   parameter int FRAC_BITS = mls_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mls_pkg::mls_cmd_type      cmd,
   output mls_pkg::mls_sts_type      sts,
   input  logic [mls_pkg::X_W-1:0]   req_tdata,
   input  logic                      csr_we,
   input  logic [mls_pkg::N_W-1:0]   csr_wdata,
   output logic [mls_pkg::ACC_W-1:0] rsp_tdata,
   output logic                      rsp_tuser
);

   import mls_pkg::*;

   // Magnitudes never exceed the smaller of 2^FRAC_BITS and 2^(X_W-1).
   localparam int MAG_W = ((FRAC_BITS < X_W - 1) ? FRAC_BITS : X_W - 1) + 1;
   localparam int XC_W  = (FRAC_BITS + 2 > X_W) ? FRAC_BITS + 2 : X_W;
   localparam logic signed [XC_W-1:0] ONE_C     = XC_W'(1) << FRAC_BITS;
   localparam logic signed [XC_W-1:0] NEG_ONE_C = -ONE_C;

   logic [N_W-1:0]          term_count_ff;
   logic [MAG_W-1:0]        x_mag_ff;
   logic                    x_neg_ff;
   logic [MAG_W-1:0]        p_mag_ff;
   logic                    p_neg_ff;
   logic [N_W-1:0]          n_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    sat_ff;
   logic                    clip;
   logic [2*MAG_W-1:0]      prod_ff;
   logic [2*MAG_W-1:0]      prod_c;
   logic [ACC_W-1:0]        log_ff;
   logic                    flag_ff;

   logic signed [XC_W-1:0]  x_ext;
   logic signed [XC_W-1:0]  x_clamp;
   logic [XC_W-1:0]         x_abs;
   logic                    term_neg;
   logic                    div_done;
   logic [MAG_W-1:0]        quot;
   logic [ACC_W:0]          q_ext;
   logic [ACC_W:0]          acc_ext;
   logic [ACC_W:0]          sum;

   // Clamp x to [-1.0, +1.0] and split it into sign and magnitude.
   assign x_ext = XC_W'($signed(req_tdata));

   always_comb begin
      if (x_ext > ONE_C) begin
         x_clamp = ONE_C;
      end else if (x_ext < NEG_ONE_C) begin
         x_clamp = NEG_ONE_C;
      end else begin
         x_clamp = x_ext;
      end
      x_abs = x_clamp[XC_W-1] ? XC_W'(-x_clamp) : XC_W'(x_clamp);
   end

   mls_div #(
      .DVD_W (MAG_W),
      .DVR_W (N_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .dividend (p_mag_ff),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (quot)
   );

   assign prod_c = p_mag_ff * x_mag_ff;

   // Odd terms add, even terms subtract, both relative to the power's sign.
   assign term_neg = p_neg_ff ^ ~n_ff[0];
   assign q_ext    = {{(ACC_W + 1 - MAG_W){1'b0}}, quot};
   assign acc_ext  = {acc_ff[ACC_W-1], acc_ff};
   assign sum      = term_neg ? acc_ext - q_ext : acc_ext + q_ext;

   always_comb begin
      clip   = 1'b0;
      acc_in = sum[ACC_W-1:0];
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         clip   = 1'b1;
         acc_in = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_COUNT_RST;
      end else if (csr_we) begin
         term_count_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_mag_ff <= x_abs[MAG_W-1:0];
         x_neg_ff <= x_clamp[XC_W-1];
         p_mag_ff <= x_abs[MAG_W-1:0];
         p_neg_ff <= x_clamp[XC_W-1];
         n_ff     <= N_W'(1);
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
      end else if (cmd.update) begin
         acc_ff   <= acc_in;
         sat_ff   <= sat_ff | clip;
         p_mag_ff <= MAG_W'(prod_ff >> FRAC_BITS);
         p_neg_ff <= p_neg_ff ^ x_neg_ff;
         n_ff     <= n_ff + 1'b1;
      end
      if (cmd.start) begin
         prod_ff <= prod_c;
      end
      if (cmd.out_load) begin
         log_ff  <= acc_ff;
         flag_ff <= sat_ff;
      end
   end

   assign sts.p_zero   = (p_mag_ff == '0);
   assign sts.n_last   = (n_ff == term_count_ff);
   assign sts.tc_zero  = (term_count_ff == '0);
   assign sts.div_done = div_done;

   assign rsp_tdata = log_ff;
   assign rsp_tuser = flag_ff;

endmodule

>>> design/mls_ctrl.sv
// Controller of the series core: sequences load, term iterations and result hand-off.
// Depends on mls_pkg.
module mls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mls_pkg::mls_cmd_type cmd,
   input  mls_pkg::mls_sts_type sts
);

   import mls_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TERM = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_TERM;
            end
         end
         S_TERM: begin
            // Once the power is zero every remaining term is zero.
            if (sts.tc_zero || sts.p_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.update = 1'b1;
               state_in   = sts.n_last ? S_DONE : S_TERM;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
